@@ design/quartic_extension_field_alu_defines.svh @@
// Assertion macros used by the checker file of the extension field ALU.
`ifndef QUARTIC_EXTENSION_FIELD_ALU_DEFINES_SVH
`define QUARTIC_EXTENSION_FIELD_ALU_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define QEF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define QEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ design/qefa_pkg.sv @@
// Shared types and constants of the quartic extension field ALU.
`timescale 1ns / 1ps
package qefa_pkg;
	localparam int unsigned FW = 48;
	localparam logic [FW-1:0] FQ_MOD = 48'hFFFF_FFFF_FFC5;
	localparam logic [6:0] FOLD = 7'd59;
	typedef logic [FW-1:0] fq_t;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_INV = 2'd3;

	// Exponent q^4 - 2 for inversion, scanned LSB first.
	localparam logic [191:0] INV_EXP = {144'd0, FQ_MOD} * {144'd0, FQ_MOD}
		* {144'd0, FQ_MOD} * {144'd0, FQ_MOD} - 192'd2;

	// datapath operations issued by the controller
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL_AB = 3'd2;
	localparam logic [2:0] OP_MUL_ACC = 3'd3;
	localparam logic [2:0] OP_SQR_BASE = 3'd4;
	localparam logic [2:0] OP_ACC_ONE = 3'd5;

	typedef struct packed {
		logic       start;
		logic [2:0] op;
	} qefa_cmd_t;

	typedef struct packed {
		logic done;
		logic a_zero;
	} qefa_sts_t;

	function automatic fq_t fq_in(input fq_t v);
		return (v >= FQ_MOD) ? v - FQ_MOD : v;
	endfunction

	function automatic fq_t fq_add(input fq_t a, input fq_t b);
		logic [FW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, FQ_MOD}) ? fq_t'(s - {1'b0, FQ_MOD}) : fq_t'(s);
	endfunction

	function automatic fq_t fq_sub(input fq_t a, input fq_t b);
		return (a >= b) ? a - b : FQ_MOD - (b - a);
	endfunction
endpackage

@@ design/qefa_mul.sv @@
// Pipelined base field multiplier mod 2^48-59 with two folds.
`timescale 1ns / 1ps
module qefa_mul import qefa_pkg::*; (
	input  logic clk,
	input  fq_t  a,
	input  fq_t  b,
	output fq_t  p
);
	logic [47:0] lo_s1, hi_s1, mid0_s1, mid1_s1;
	logic [48:0] mid_s2;
	logic [47:0] lo_s2, hi_s2;
	logic [48:0] low_w;
	logic [53:0] t_s3;
	logic [47:0] high_w;
	logic [48:0] x_w;

	always_ff @(posedge clk) begin
		lo_s1 <= a[23:0] * b[23:0];
		mid0_s1 <= a[47:24] * b[23:0];
		mid1_s1 <= a[23:0] * b[47:24];
		hi_s1 <= a[47:24] * b[47:24];
		mid_s2 <= {1'b0, mid0_s1} + {1'b0, mid1_s1};
		lo_s2 <= lo_s1;
		hi_s2 <= hi_s1;
	end

	// the full product is below 2^96, so the high half fits in 48 bits
	always_comb begin
		low_w = {1'b0, lo_s2} + {1'b0, mid_s2[23:0], 24'd0};
		high_w = hi_s2 + {23'd0, mid_s2[48:24]} + {47'd0, low_w[48]};
	end

	always_ff @(posedge clk) begin
		t_s3 <= {6'd0, low_w[47:0]} + 54'(high_w) * 54'(FOLD);
	end

	always_comb begin
		x_w = {1'b0, t_s3[47:0]} + 49'(t_s3[53:48]) * 49'(FOLD);
	end

	always_ff @(posedge clk) begin
		p <= (x_w >= {1'b0, FQ_MOD}) ? fq_t'(x_w - {1'b0, FQ_MOD}) : fq_t'(x_w);
	end
endmodule

@@ design/qefa_datapath.sv @@
// Datapath: operand and accumulator registers, shared multiplier, schoolbook sequencer.
`timescale 1ns / 1ps
module qefa_datapath import qefa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  qefa_cmd_t cmd,
	input  fq_t       a_in [4],
	input  fq_t       b_in [4],
	output fq_t       r [4],
	output qefa_sts_t sts
);
	localparam logic [4:0] LAT = 5'd4;
	localparam logic [4:0] CNT_LAST = 5'd31;

	typedef struct packed {
		logic       hit;
		logic [2:0] src;
		logic       four;
	} fold_slot_t;

	fq_t a_q [4];
	fq_t b_q [4];
	fq_t acc_q [4];
	fq_t t_q [7];
	fq_t ma, mb, mp;
	logic busy_q;
	logic done_q;
	logic [2:0] op_q;
	logic [4:0] cnt_q;
	logic [4:0] ret_w;
	logic [2:0] tgt_w;
	logic is_mul_w;
	fold_slot_t fi_w, fr_w;

	// fold products: 4*t[j] adds into t[j-2], 2*t[j] subtracts from t[j-4];
	// the x^4 pair is issued only after 4*t6 has landed in t4
	function automatic fold_slot_t fold_slot(input logic [4:0] c);
		fold_slot_t s;
		s = '{hit: 1'b1, src: 3'd6, four: 1'b1};
		case (c)
			5'd20: s = '{hit: 1'b1, src: 3'd6, four: 1'b1};
			5'd21: s = '{hit: 1'b1, src: 3'd6, four: 1'b0};
			5'd22: s = '{hit: 1'b1, src: 3'd5, four: 1'b1};
			5'd23: s = '{hit: 1'b1, src: 3'd5, four: 1'b0};
			5'd25: s = '{hit: 1'b1, src: 3'd4, four: 1'b1};
			5'd26: s = '{hit: 1'b1, src: 3'd4, four: 1'b0};
			default: s.hit = 1'b0;
		endcase
		return s;
	endfunction

	qefa_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	// issue 16 products at cnt 0..15; each retires when it leaves the multiplier
	assign ret_w = cnt_q - LAT;
	assign fi_w = fold_slot(cnt_q);
	assign fr_w = fold_slot(ret_w);
	assign tgt_w = fr_w.four ? fr_w.src - 3'd2 : fr_w.src - 3'd4;
	assign is_mul_w = (cmd.op == OP_MUL_AB) || (cmd.op == OP_MUL_ACC)
		|| (cmd.op == OP_SQR_BASE);

	always_comb begin
		if (fi_w.hit) begin
			ma = fi_w.four ? fq_t'(4) : fq_t'(2);
			mb = t_q[fi_w.src];
		end else begin
			ma = (op_q == OP_MUL_ACC) ? acc_q[cnt_q[3:2]] : a_q[cnt_q[3:2]];
			mb = (op_q == OP_MUL_AB) ? b_q[cnt_q[1:0]] : a_q[cnt_q[1:0]];
		end
	end

	assign r = acc_q;
	assign sts = '{done: done_q, a_zero: (a_q[0] | a_q[1] | a_q[2] | a_q[3]) == '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_ADD;
		end else if (cmd.start) begin
			op_q <= cmd.op;
			cnt_q <= '0;
			busy_q <= is_mul_w;
			done_q <= !is_mul_w;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			busy_q <= cnt_q != CNT_LAST;
			done_q <= cnt_q == CNT_LAST;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 4; k++) begin
				a_q[k] <= fq_in(a_in[k]);
				b_q[k] <= fq_in(b_in[k]);
			end
		end else if (cmd.start) begin
			case (cmd.op)
				OP_ADD: begin
					for (int k = 0; k < 4; k++) acc_q[k] <= fq_add(a_q[k], b_q[k]);
				end
				OP_SUB: begin
					for (int k = 0; k < 4; k++) acc_q[k] <= fq_sub(a_q[k], b_q[k]);
				end
				OP_ACC_ONE: begin
					acc_q[0] <= fq_t'(1);
					for (int k = 1; k < 4; k++) acc_q[k] <= '0;
				end
				default: begin
					for (int k = 0; k < 7; k++) t_q[k] <= '0;
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q >= LAT && cnt_q < LAT + 5'd16)
				t_q[3'(ret_w[3:2]) + 3'(ret_w[1:0])] <=
					fq_add(t_q[3'(ret_w[3:2]) + 3'(ret_w[1:0])], mp);
			if (fr_w.hit)
				t_q[tgt_w] <= fr_w.four ? fq_add(t_q[tgt_w], mp) : fq_sub(t_q[tgt_w], mp);
			if (cnt_q == CNT_LAST) begin
				if (op_q == OP_SQR_BASE) begin
					for (int k = 0; k < 4; k++) a_q[k] <= t_q[k];
				end else begin
					for (int k = 0; k < 4; k++) acc_q[k] <= t_q[k];
				end
			end
		end
	end
endmodule

@@ design/qefa_ctrl.sv @@
// Controller: sequences add/sub, one multiply, or square-and-multiply inversion.
`timescale 1ns / 1ps
module qefa_ctrl import qefa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [1:0] command,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      err,
	output logic      load,
	output qefa_cmd_t cmd,
	input  qefa_sts_t sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_INV = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;
	localparam logic [7:0] BIT_END = 8'd192;

	logic [2:0] state_q;
	logic [1:0] cmd_q;
	logic [7:0] bit_q;
	logic sqr_q;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = state_q == S_OUT;
	// operands are captured by the datapath at the accepting edge
	assign load = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_ADD;
			bit_q <= '0;
			sqr_q <= 1'b0;
			err <= 1'b0;
			cmd <= '0;
		end else begin
			case (state_q)
				S_IDLE, S_OUT: begin
					cmd <= '0;
					if (load) begin
						cmd_q <= command;
						state_q <= S_DISP;
					end else if (state_q == S_OUT && out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_DISP: begin
					err <= (cmd_q == CMD_INV) && sts.a_zero;
					bit_q <= '0;
					sqr_q <= 1'b0;
					case (cmd_q)
						CMD_ADD: cmd <= '{start: 1'b1, op: OP_ADD};
						CMD_SUB: cmd <= '{start: 1'b1, op: OP_SUB};
						CMD_MUL: cmd <= '{start: 1'b1, op: OP_MUL_AB};
						default: cmd <= '{start: 1'b1, op: OP_ACC_ONE};
					endcase
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					cmd <= '0;
					if (sts.done) begin
						if (cmd_q == CMD_INV && !err && bit_q != BIT_END) state_q <= S_INV;
						else state_q <= S_OUT;
					end
				end
				S_INV: begin
					// multiply acc by base when bit set, then square base
					if (!sqr_q && INV_EXP[bit_q]) begin
						cmd <= '{start: 1'b1, op: OP_MUL_ACC};
					end else begin
						cmd <= '{start: 1'b1, op: OP_SQR_BASE};
						bit_q <= bit_q + 8'd1;
					end
					sqr_q <= !sqr_q && INV_EXP[bit_q];
					state_q <= S_WAIT;
				end
				default: begin
					cmd <= '0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ design/quartic_extension_field_alu.sv @@
// Top level of the GF(q^4) arithmetic unit, q = 2^48-59.
// Usage:
//  Input channel in_valid/in_ready takes one item: command plus operands a and b.
//  Output channel out_valid/out_ready returns r_c0..r_c3 and zero_inverse_error.
//  One item is in flight at a time; a new item is accepted in the cycle the
//  previous result is taken. A multiply runs on the single shared 4-stage
//  48-bit modular multiplier: 16 partial products and then 6 reduction
//  products for x^6, x^5, x^4. Invert runs 192 squarings and 104 multiplies
//  over the exponent q^4-2. Inverting zero returns zero with
//  zero_inverse_error high. Reset clears all control state; no item is
//  pending after reset. When the receiver stalls the result holds on the
//  outputs and no new item is accepted until it is taken.
`timescale 1ns / 1ps
module quartic_extension_field_alu import qefa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [47:0] a_c0, a_c1, a_c2, a_c3,
	input  logic [47:0] b_c0, b_c1, b_c2, b_c3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] r_c0, r_c1, r_c2, r_c3,
	output logic        zero_inverse_error
);
	qefa_cmd_t cmd;
	qefa_sts_t sts;
	fq_t a_w [4];
	fq_t b_w [4];
	fq_t r_w [4];
	logic err;
	logic load;

	assign a_w = '{a_c0, a_c1, a_c2, a_c3};
	assign b_w = '{b_c0, b_c1, b_c2, b_c3};

	qefa_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .command,
		.out_valid, .out_ready, .err, .load, .cmd, .sts);

	qefa_datapath u_dp (.clk, .arst_n, .load, .cmd, .a_in(a_w), .b_in(b_w),
		.r(r_w), .sts);

	assign r_c0 = err ? '0 : r_w[0];
	assign r_c1 = err ? '0 : r_w[1];
	assign r_c2 = err ? '0 : r_w[2];
	assign r_c3 = err ? '0 : r_w[3];
	assign zero_inverse_error = err;
endmodule

@@ design/qefa_checker.sv @@
// Port-level checker for the extension field ALU, bound to the top level.
`timescale 1ns / 1ps
`include "quartic_extension_field_alu_defines.svh"
module qefa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] r_c0,
	input logic        zero_inverse_error
);
	`QEF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`QEF_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && zero_inverse_error, r_c0 == 48'd0, "err nonzero")
	`QEF_ASSERT_IMPL(a_canon, clk, arst_n, out_valid, r_c0 < 48'hFFFF_FFFF_FFC5, "not canonical")
	`QEF_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid, "early out")
endmodule

bind quartic_extension_field_alu qefa_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .r_c0, .zero_inverse_error);

@@ sim/testbench.sv @@
// Self-checking testbench of the GF(q^4) arithmetic unit, with a modular predictor.
`timescale 1ns / 1ps
module testbench;
	import qefa_pkg::*;

	typedef logic [3:0][47:0] elem_t;
	typedef struct {
		logic [1:0] cmd;
		elem_t      a;
		elem_t      b;
	} op_item_t;
	typedef struct {
		elem_t r;
		logic  err;
	} field_result_t;

	localparam int N_RANDOM = 750;
	localparam int STALL_LIMIT = 60000;
	localparam int SENDER_IDLE_1 = 28;
	localparam int RECEIVER_IDLE_1 = 79;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = CMD_ADD;
	logic [47:0] a_c0 = '0, a_c1 = '0, a_c2 = '0, a_c3 = '0;
	logic [47:0] b_c0 = '0, b_c1 = '0, b_c2 = '0, b_c3 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [47:0] r_c0, r_c1, r_c2, r_c3;
	logic        zero_inverse_error;

	op_item_t      pending_ops[$];
	field_result_t expected_results[$];
	int            n_total = 0;
	int            n_accepted = 0;
	int            n_errors = 0;
	int            stall_cycles = 0;
	logic [191:0]  inv_power;

	quartic_extension_field_alu DUT (.*);

	always #2 clk = ~clk;

	// --- base field arithmetic, operands canonical ---
	function automatic fq_t reduce_in(input fq_t v);
		return (v >= FQ_MOD) ? v - FQ_MOD : v;
	endfunction

	function automatic fq_t fq_plus(input fq_t x, input fq_t y);
		logic [48:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, FQ_MOD})
			s = s - {1'b0, FQ_MOD};
		return s[47:0];
	endfunction

	function automatic fq_t fq_minus(input fq_t x, input fq_t y);
		return (x >= y) ? x - y : FQ_MOD - (y - x);
	endfunction

	function automatic fq_t fq_times(input fq_t x, input fq_t y);
		logic [95:0] p;
		p = {48'd0, x} * {48'd0, y};
		p = p % {48'd0, FQ_MOD};
		return p[47:0];
	endfunction

	// --- extension field, x^4 = 4x^2 - 2 ---
	function automatic elem_t quartic_mul(input elem_t x, input elem_t y);
		fq_t   t[7];
		elem_t r;
		for (int i = 0; i < 7; i++)
			t[i] = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				t[i+j] = fq_plus(t[i+j], fq_times(x[i], y[j]));
		for (int j = 6; j >= 4; j--) begin
			t[j-2] = fq_plus(t[j-2], fq_times(48'd4, t[j]));
			t[j-4] = fq_minus(t[j-4], fq_times(48'd2, t[j]));
		end
		for (int i = 0; i < 4; i++)
			r[i] = t[i];
		return r;
	endfunction

	function automatic elem_t quartic_inverse(input elem_t x, input logic [191:0] e);
		elem_t base_e;
		elem_t prod;
		base_e = x;
		prod = '0;
		prod[0] = 48'd1;
		for (int k = 0; k < 192; k++) begin
			if (e[k])
				prod = quartic_mul(prod, base_e);
			base_e = quartic_mul(base_e, base_e);
		end
		return prod;
	endfunction

	function automatic field_result_t alu_predict(input op_item_t it, input logic [191:0] e);
		field_result_t res;
		elem_t a;
		elem_t b;
		for (int i = 0; i < 4; i++) begin
			a[i] = reduce_in(it.a[i]);
			b[i] = reduce_in(it.b[i]);
		end
		res.r = '0;
		res.err = 1'b0;
		case (it.cmd)
			CMD_ADD: begin
				for (int i = 0; i < 4; i++)
					res.r[i] = fq_plus(a[i], b[i]);
			end
			CMD_SUB: begin
				for (int i = 0; i < 4; i++)
					res.r[i] = fq_minus(a[i], b[i]);
			end
			CMD_MUL: res.r = quartic_mul(a, b);
			default: begin
				if (a == '0)
					res.err = 1'b1;
				else
					res.r = quartic_inverse(a, e);
			end
		endcase
		return res;
	endfunction

	// --- stimulus helpers ---
	function automatic fq_t rand_coef();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return FQ_MOD - 48'd1 - 48'($urandom_range(0, 7));
			2: return FQ_MOD + 48'($urandom_range(0, 58));
			3: return 48'($urandom_range(0, 15));
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	function automatic elem_t rand_elem();
		elem_t v;
		for (int i = 0; i < 4; i++)
			v[i] = rand_coef();
		return v;
	endfunction

	function automatic elem_t splat(input fq_t v);
		elem_t e;
		for (int i = 0; i < 4; i++)
			e[i] = v;
		return e;
	endfunction

	task automatic push_op(input logic [1:0] cmd, input elem_t a, input elem_t b);
		op_item_t it;
		it.cmd = cmd;
		it.a = a;
		it.b = b;
		pending_ops = {pending_ops, it};
		n_total++;
	endtask

	function automatic int sender_idle_pct();
		if (n_accepted < n_total / 3)
			return SENDER_IDLE_1;
		else if (n_accepted < 2 * n_total / 3)
			return RECEIVER_IDLE_1;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_accepted < n_total / 3)
			return RECEIVER_IDLE_1;
		else if (n_accepted < 2 * n_total / 3)
			return SENDER_IDLE_1;
		return 0;
	endfunction

	// --- driver ---
	always @(posedge clk or negedge arst_n) begin
		op_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					it = pending_ops.pop_front();
					in_valid <= 1'b1;
					command <= it.cmd;
					{a_c3, a_c2, a_c1, a_c0} <= it.a;
					{b_c3, b_c2, b_c1, b_c0} <= it.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// --- monitor, scoreboard and watchdog ---
	always @(posedge clk) begin
		op_item_t      it;
		field_result_t want;
		elem_t         got;
		logic          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				it.cmd = command;
				it.a = {a_c3, a_c2, a_c1, a_c0};
				it.b = {b_c3, b_c2, b_c1, b_c0};
				expected_results = {expected_results, alu_predict(it, inv_power)};
				n_accepted <= n_accepted + 1;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got = {r_c3, r_c2, r_c1, r_c0};
				if (expected_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: unexpected result r=%h err=%b", got,
							zero_inverse_error);
				end else begin
					want = expected_results.pop_front();
					if (got !== want.r || zero_inverse_error !== want.err) begin
						n_errors++;
						if (n_errors <= 10)
							$display("ERROR: result r=%h err=%b, expected r=%h err=%b",
								got, zero_inverse_error, want.r, want.err);
					end
				end
			end
			stall_cycles <= moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("ERROR: timeout, no item moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [191:0] q;
		elem_t one_e;
		q = {144'd0, FQ_MOD};
		inv_power = q * q * q * q - 192'd2;
		one_e = '0;
		one_e[0] = 48'd1;

		// extremes, non-canonical inputs and each command
		push_op(CMD_ADD, splat('0), splat('0));
		push_op(CMD_ADD, splat(FQ_MOD - 48'd1), splat(FQ_MOD - 48'd1));
		push_op(CMD_ADD, splat(48'hFFFF_FFFF_FFFF), splat(FQ_MOD));
		push_op(CMD_SUB, splat('0), splat(FQ_MOD - 48'd1));
		push_op(CMD_SUB, splat(48'hFFFF_FFFF_FFFF), splat('0));
		push_op(CMD_SUB, rand_elem(), rand_elem());
		push_op(CMD_MUL, splat(FQ_MOD - 48'd1), splat(FQ_MOD - 48'd1));
		push_op(CMD_MUL, splat(48'hFFFF_FFFF_FFFF), splat(48'hFFFF_FFFF_FFFF));
		push_op(CMD_MUL, one_e, rand_elem());
		push_op(CMD_MUL, rand_elem(), splat('0));
		push_op(CMD_INV, splat('0), rand_elem());
		push_op(CMD_INV, splat(FQ_MOD), splat('0));
		push_op(CMD_INV, one_e, splat('0));
		push_op(CMD_INV, splat(48'hFFFF_FFFF_FFFF), splat('0));
		push_op(CMD_INV, rand_elem(), rand_elem());

		// random part; keep inversions rare since each one is slow
		for (int n = 0; n < N_RANDOM; n++) begin
			int pick;
			logic [1:0] cmd;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				cmd = CMD_INV;
			else if (pick < 36)
				cmd = CMD_ADD;
			else if (pick < 68)
				cmd = CMD_SUB;
			else
				cmd = CMD_MUL;
			push_op(cmd, rand_elem(), rand_elem());
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);

		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
